[rtl/rsem_pkg.sv]
// ----------------------------------------------------------------------------
// rsem_pkg
// shared types and constants of the rgb sobel energy map block
// ----------------------------------------------------------------------------
package rsem_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // counter and size widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  // register port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam int WIDTH_RESET  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int HEIGHT_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // pixel and result fields
  localparam int PIX_W      = 8;
  localparam int ENERGY_W   = 15;
  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 11;

  // gray conversion: sum / 3 as a multiply by a reciprocal
  localparam int SUM3_W   = PIX_W + 2;
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;

  // gradient and magnitude
  localparam int GRAD_W = PIX_W + 3;
  localparam int MAG_W  = GRAD_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SSQ_W  = SQ_W + 1;
  localparam int FRAC_W = 4;
  localparam int ROOT_W = ENERGY_W;
  localparam int RAD_W  = 2 * ROOT_W;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]  energy;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 last_in_run;
    logic                 frame_done;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_t;

endpackage

[rtl/rgb_sobel_energy_map_top.sv]
// ----------------------------------------------------------------------------
// rgb_sobel_energy_map_top
// streaming 3x3 sobel gradient magnitude of an rgb image, edge replicated
// ----------------------------------------------------------------------------
//
//  channel | signals                          | carries
//  --------+----------------------------------+------------------------------
//  pixel   | pix_valid, pix_ready, pix        | one rgb pixel, raster order
//  result  | res_valid, res_ready, res        | energy, position, flags
//  config  | cfg_valid, cfg_ready, cfg_index, | frame width / frame height
//          | cfg_data                         |
//
//  a pixel releases 0 to 4 results, worked out one after another; the
//  15-step serial square root sets the per-result cost
//  one pixel is in flight at a time; the result register lets the next pixel
//  transfer while the last result still waits for res_ready
//  rst is synchronous; the line buffer memory is not cleared and needs no pass
//  config transfers are taken in any cycle, cfg_ready stays high
//
module rgb_sobel_energy_map_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  rsem_pkg::pixel_t               pix,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rsem_pkg::result_t              res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsem_pkg::CFG_W-1:0]     cfg_data
);
  import rsem_pkg::*;

  // sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;  // wait for a pixel
  localparam logic [ST_W-1:0] ST_READ = 3'd1;  // line data back, shift window
  localparam logic [ST_W-1:0] ST_GRAD = 3'd2;  // gx, gy of one result
  localparam logic [ST_W-1:0] ST_SQX  = 3'd3;  // gx squared
  localparam logic [ST_W-1:0] ST_SQY  = 3'd4;  // add gy squared, start root
  localparam logic [ST_W-1:0] ST_ROOT = 3'd5;  // wait for the square root
  localparam logic [ST_W-1:0] ST_EMIT = 3'd6;  // hand result to output reg

  // result slots of one pixel, in delivery order
  localparam int NUM_SLOT = 4;
  localparam logic [1:0] SLOT_PREV_LEFT = 2'd0;  // row above, column to the left
  localparam logic [1:0] SLOT_PREV_OWN  = 2'd1;  // row above, own column
  localparam logic [1:0] SLOT_LAST_LEFT = 2'd2;  // last row, column to the left
  localparam logic [1:0] SLOT_LAST_OWN  = 2'd3;  // last row, own column

  function automatic logic [WID_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      clamp_w = WID_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      clamp_w = WID_W'(MAX_WIDTH);
    end else begin
      clamp_w = WID_W'(v);
    end
  endfunction

  function automatic logic [HGT_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      clamp_h = HGT_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      clamp_h = HGT_W'(MAX_HEIGHT);
    end else begin
      clamp_h = HGT_W'(v);
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick3(input logic [PIX_W-1:0] a0,
                                             input logic [PIX_W-1:0] a1,
                                             input logic [PIX_W-1:0] a2,
                                             input logic [1:0]       s);
    case (s)
      2'd0:    pick3 = a0;
      2'd1:    pick3 = a1;
      default: pick3 = a2;
    endcase
  endfunction

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] v);
    ext = $signed(GRAD_W'(v));
  endfunction

  // control
  logic [ST_W-1:0]     state;
  logic [NUM_SLOT-1:0] pend;
  logic [WID_W-1:0]    width_eff;
  logic [HGT_W-1:0]    height_eff;
  logic [COL_W-1:0]    col_count;
  logic [ROW_W-1:0]    row_count;

  // current pixel
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [PIX_W-1:0]    gray;

  // line buffers, upper and middle side by side in one memory
  line_t               line_mem [MAX_WIDTH];
  line_t               rd_line;

  // 3x3 window, [row][column], row 0 on top, column 2 newest
  logic [PIX_W-1:0]    win [3][3];

  // arithmetic path
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic [SQ_W-1:0]          sq;

  // accept side
  logic                pix_xfer;
  logic [SUM3_W-1:0]   sum3;
  logic [SUM3_W+DIV3_SH-1:0] div3_prod;
  logic [PIX_W-1:0]    gray_c;
  logic                last_col;
  logic                last_row;
  logic [NUM_SLOT-1:0] pend_init;

  // slot decode
  logic [1:0]          slot;
  logic [NUM_SLOT-1:0] slot_hot;
  logic [NUM_SLOT-1:0] pend_left;
  logic                slot_own;
  logic                slot_prev;
  logic [1:0]          top_sel, mid_sel, bot_sel;
  logic [1:0]          lk_sel, ck_sel, rk_sel;
  logic [PIX_W-1:0]    lcol [3];
  logic [PIX_W-1:0]    ccol [3];
  logic [PIX_W-1:0]    rcol [3];
  logic [PIX_W-1:0]    tl, tc, tr, ml, mr, bl, bc, br;
  logic signed [GRAD_W-1:0] gx_c;
  logic signed [GRAD_W-1:0] gy_c;
  logic [MAG_W-1:0]    ax, ay, mul_a;
  logic [SQ_W-1:0]     mul_p;
  logic [SSQ_W-1:0]    ssq;

  // square root unit
  logic                sq_start;
  logic [RAD_W-1:0]    sq_rad;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;

  assign pix_ready = (state == ST_IDLE);
  assign pix_xfer  = pix_valid && pix_ready;
  assign cfg_ready = 1'b1;

  // gray = floor(sum / 3), exact for sums up to 765
  always_comb begin
    sum3      = SUM3_W'(pix.red) + SUM3_W'(pix.green) + SUM3_W'(pix.blue);
    div3_prod = (SUM3_W + DIV3_SH)'(sum3) * (SUM3_W + DIV3_SH)'(DIV3_MUL);
    gray_c    = div3_prod[DIV3_SH +: PIX_W];
  end

  // which results this pixel releases; >= covers a frame that shrank mid-way
  always_comb begin
    last_col  = (WID_W'(col_count) + WID_W'(1)) >= width_eff;
    last_row  = (HGT_W'(row_count) + HGT_W'(1)) >= height_eff;
    pend_init = '0;
    pend_init[SLOT_PREV_LEFT] = (row_count != '0) && (col_count != '0);
    pend_init[SLOT_PREV_OWN]  = (row_count != '0) && last_col;
    pend_init[SLOT_LAST_LEFT] = last_row && (col_count != '0);
    pend_init[SLOT_LAST_OWN]  = last_row && last_col;
  end

  // lowest pending slot goes next
  always_comb begin
    if (pend[SLOT_PREV_LEFT]) begin
      slot = SLOT_PREV_LEFT;
    end else if (pend[SLOT_PREV_OWN]) begin
      slot = SLOT_PREV_OWN;
    end else if (pend[SLOT_LAST_LEFT]) begin
      slot = SLOT_LAST_LEFT;
    end else begin
      slot = SLOT_LAST_OWN;
    end
    slot_hot  = NUM_SLOT'(1) << slot;
    pend_left = pend & ~slot_hot;
    slot_own  = (slot == SLOT_PREV_OWN) || (slot == SLOT_LAST_OWN);
    slot_prev = (slot == SLOT_PREV_LEFT) || (slot == SLOT_PREV_OWN);
  end

  // window rows and columns, replicating the frame edge
  always_comb begin
    if (slot_prev) begin
      top_sel = (cur_row == ROW_W'(1)) ? 2'd1 : 2'd0;
      mid_sel = 2'd1;
      bot_sel = 2'd2;
    end else begin
      top_sel = (cur_row == '0) ? 2'd2 : 2'd1;
      mid_sel = 2'd2;
      bot_sel = 2'd2;
    end
    if (slot_own) begin
      lk_sel = (cur_col == '0) ? 2'd2 : 2'd1;
      ck_sel = 2'd2;
      rk_sel = 2'd2;
    end else begin
      lk_sel = (cur_col == COL_W'(1)) ? 2'd1 : 2'd0;
      ck_sel = 2'd1;
      rk_sel = 2'd2;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lcol[i] = pick3(win[i][0], win[i][1], win[i][2], lk_sel);
      ccol[i] = pick3(win[i][0], win[i][1], win[i][2], ck_sel);
      rcol[i] = pick3(win[i][0], win[i][1], win[i][2], rk_sel);
    end
    tl = pick3(lcol[0], lcol[1], lcol[2], top_sel);
    tc = pick3(ccol[0], ccol[1], ccol[2], top_sel);
    tr = pick3(rcol[0], rcol[1], rcol[2], top_sel);
    ml = pick3(lcol[0], lcol[1], lcol[2], mid_sel);
    mr = pick3(rcol[0], rcol[1], rcol[2], mid_sel);
    bl = pick3(lcol[0], lcol[1], lcol[2], bot_sel);
    bc = pick3(ccol[0], ccol[1], ccol[2], bot_sel);
    br = pick3(rcol[0], rcol[1], rcol[2], bot_sel);
  end

  // sobel: gx left minus right, gy top minus bottom, weights 1 2 1
  always_comb begin
    gx_c = ext(tl) - ext(tr) + ((ext(ml) - ext(mr)) <<< 1) + ext(bl) - ext(br);
    gy_c = ext(tl) - ext(bl) + ((ext(tc) - ext(bc)) <<< 1) + ext(tr) - ext(br);
  end

  // one shared multiplier squares gx, then gy
  always_comb begin
    ax    = gx[GRAD_W-1] ? MAG_W'(-gx) : MAG_W'(gx);
    ay    = gy[GRAD_W-1] ? MAG_W'(-gy) : MAG_W'(gy);
    mul_a = (state == ST_SQX) ? ax : ay;
    mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);
    ssq   = SSQ_W'(sq) + SSQ_W'(mul_p);
  end

  // root of 256 * (gx^2 + gy^2) gives 4 fractional bits
  assign sq_start = (state == ST_SQY);
  assign sq_rad   = RAD_W'(ssq) << (2 * FRAC_W);

  rsem_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // line buffer: read at transfer, write back in the cycle after
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      line_mem[cur_col] <= '{upper: rd_line.middle, middle: gray};
    end
    if (pix_xfer) begin
      rd_line <= line_mem[col_count];
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (state == ST_READ) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= rd_line.upper;
      win[1][2] <= rd_line.middle;
      win[2][2] <= gray;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WID_W'(WIDTH_RESET);
      height_eff <= HGT_W'(HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_eff  <= clamp_w(cfg_data);
        REG_FRAME_HEIGHT: height_eff <= clamp_h(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= '0;
      col_count <= '0;
      row_count <= '0;
      res_valid <= 1'b0;
    end else begin
      // in the emit state the result register is updated below
      if (res_valid && res_ready && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pix_valid) begin
            cur_col <= col_count;
            cur_row <= row_count;
            gray    <= gray_c;
            pend    <= pend_init;
            if (last_col) begin
              col_count <= '0;
              row_count <= last_row ? '0 : row_count + ROW_W'(1);
            end else begin
              col_count <= col_count + COL_W'(1);
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= (pend != '0) ? ST_GRAD : ST_IDLE;
        end
        ST_GRAD: begin
          gx    <= gx_c;
          gy    <= gy_c;
          state <= ST_SQX;
        end
        ST_SQX: begin
          sq    <= mul_p;
          state <= ST_SQY;
        end
        ST_SQY: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid       <= 1'b1;
            res.energy      <= sq_root;
            res.out_col     <= slot_own ? OUT_COL_W'(cur_col)
                                        : OUT_COL_W'(cur_col - COL_W'(1));
            res.out_row     <= slot_prev ? OUT_ROW_W'(cur_row - ROW_W'(1))
                                         : OUT_ROW_W'(cur_row);
            res.last_in_run <= (pend_left == '0);
            res.frame_done  <= (slot == SLOT_LAST_OWN);
            pend            <= pend_left;
            state           <= (pend_left != '0) ? ST_GRAD : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // root unit only finishes while the sequencer waits for it
  a_root_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_ROOT))
    else $error("square root finished outside the wait state");

  // every result step works on a pending slot
  a_pend_while_busy : assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRAD || state == ST_SQX || state == ST_SQY ||
     state == ST_ROOT || state == ST_EMIT) |-> (pend != '0))
    else $error("result step with no pending slot");

  // the final pixel of the frame always closes its run
  a_frame_done_last : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.frame_done || res.last_in_run))
    else $error("frame_done result is not last in run");

  // no new pixel until the previous one is fully processed
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!res_valid || res_ready) && pend_left != '0)
      |=> !pix_ready)
    else $error("pixel taken while results still pending");

endmodule

[rtl/rsem_isqrt.sv]
// ----------------------------------------------------------------------------
// rsem_isqrt
// bit-serial integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rsem_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsem_pkg::RAD_W-1:0] radicand,
  output logic                       done,
  output logic [rsem_pkg::ROOT_W-1:0] root
);
  import rsem_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(ROOT_W - 1));
      if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        rad <= rad << 2;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the rgb sobel energy map block against a cycle-free predictor:
// a directed stimulus table (borders, clamped sizes, mid-frame shrink,
// one-row and one-column frames) is followed by random frames under three
// idle profiles and a long result stall
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsem_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  // settle margin for one pixel that releases four results
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 260;
  localparam int STALL_CYCLES  = 400;
  localparam int MAX_REPORTS   = 10;
  // about 300 pixels plus settle gaps fit well inside this limit
  localparam longint LIMIT_CYCLES = 2_000_000;

  // unmapped register index, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // ---------------------------------------------------------------------------
  // directed stimulus table
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      value;
    pixel_t                px;
    logic                  typed;   // energy below is the expected value of every result
    logic [ENERGY_W-1:0]   energy;
  } stim_row_t;

  localparam int NUM_ROWS = 31;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // reset size 640x480: first row pixels release nothing
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFF0000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h00FF00, 1'b0, 15'd0},
    // zero sizes act as 1; the column counter now lies beyond the frame
    '{ROW_REG,   REG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0, 15'd0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'd0,    24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h0000FF, 1'b0, 15'd0},
    // 1x1 frames: fully replicated neighborhood, no gradient
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b1, 15'd0},
    '{ROW_REG,   REG_SPARE,        12'hFFF,  24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h5A3C1E, 1'b1, 15'd0},
    // 2x1 frame, black then white: |gx| = 4*255 on both pixels
    '{ROW_REG,   REG_FRAME_WIDTH,  12'd2,    24'h000000, 1'b0, 15'd0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'd1,    24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b1, 15'd16320},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1, 15'd16320},
    // one-column frame of three rows
    '{ROW_REG,   REG_FRAME_WIDTH,  12'd1,    24'h000000, 1'b0, 15'd0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'd3,    24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h102030, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0, 15'd0},
    // oversized values clamp to the maximum
    '{ROW_REG,   REG_FRAME_WIDTH,  12'hFFF,  24'h000000, 1'b0, 15'd0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'hFFF,  24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h808080, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h7F7F7F, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h010101, 1'b0, 15'd0},
    // shrink to 3x2 mid-row: column 3 ends the row, row 1 becomes the last
    '{ROW_REG,   REG_FRAME_WIDTH,  12'd3,    24'h000000, 1'b0, 15'd0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'd2,    24'h000000, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h00FF00, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hFF00FF, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'h0F0F0F, 1'b0, 15'd0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0,    24'hF0F0F0, 1'b0, 15'd0}
  };

  // ---------------------------------------------------------------------------
  // block ports
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_ready;
  pixel_t               pix;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rgb_sobel_energy_map_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the registers, line buffers and window
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_w;
  logic [CFG_W-1:0] frame_h;
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];   // [row: top, middle, bottom][column: left, center, right]

  result_t energies_due [$];      // energies still owed by the block, oldest first
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      stall_request;         // cycles of result hold-off asked of the receiver

  // effective frame size, zero acts as one and the top clamps
  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
    return (v == 0) ? 1 : ((v > lim) ? lim : v);
  endfunction

  // floor(16 * sqrt(gx^2 + gy^2)) over the given window rows and columns
  function automatic logic [ENERGY_W-1:0] energy_at(input int t, input int m, input int b,
                                                    input int l, input int k, input int rt);
    int          gx;
    int          gy;
    longint      rad;
    int unsigned root;
    int unsigned cand;
    gx = int'(win[t][l]) - int'(win[t][rt]) + 2 * (int'(win[m][l]) - int'(win[m][rt]))
       + int'(win[b][l]) - int'(win[b][rt]);
    gy = int'(win[t][l]) - int'(win[b][l]) + 2 * (int'(win[t][k]) - int'(win[b][k]))
       + int'(win[t][rt]) - int'(win[b][rt]);
    rad = 256 * longint'(gx * gx + gy * gy);
    // integer square root, one result bit at a time from the top
    root = 0;
    for (int bt = 15; bt >= 0; bt--) begin
      cand = root | (32'd1 << bt);
      if (longint'(cand) * longint'(cand) <= rad) root = cand;
    end
    return ENERGY_W'(root);
  endfunction

  // advance the predictor by one accepted pixel, return the energies it releases
  function automatic int unsigned energy_for_pixel(input pixel_t px, output result_t outs [4]);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      slot;
    int unsigned      n;
    int               top;
    int               lft;
    logic [PIX_W-1:0] gray;
    logic             last_col;
    logic             last_row;
    w = eff_size(frame_w, MAX_WIDTH);
    h = eff_size(frame_h, MAX_HEIGHT);
    c = col_cnt;
    r = row_cnt;
    slot = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    gray = PIX_W'((int'(px.red) + int'(px.green) + int'(px.blue)) / 3);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_mem[slot];
    win[1][2] = middle_mem[slot];
    win[2][2] = gray;
    upper_mem[slot]  = middle_mem[slot];
    middle_mem[slot] = gray;
    // counters past a shrunk frame count as its last column or row
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    n = 0;
    for (int k = 0; k < 4; k++) outs[k] = '0;
    // the row above now has its lower neighbors
    if (r >= 1) begin
      top = (r == 1) ? 1 : 0;
      if (c >= 1) begin
        lft = (c == 1) ? 1 : 0;
        outs[n] = '{energy_at(top, 1, 2, lft, 1, 2), OUT_COL_W'(c - 1), OUT_ROW_W'(r - 1),
                    1'b0, 1'b0};
        n++;
      end
      if (last_col) begin
        lft = (c == 0) ? 2 : 1;
        outs[n] = '{energy_at(top, 1, 2, lft, 2, 2), OUT_COL_W'(c), OUT_ROW_W'(r - 1),
                    1'b0, 1'b0};
        n++;
      end
    end
    // last row: bottom replicates, results follow one pixel behind, the last column's at once
    if (last_row) begin
      top = (r == 0) ? 2 : 1;
      if (c >= 1) begin
        lft = (c == 1) ? 1 : 0;
        outs[n] = '{energy_at(top, 2, 2, lft, 1, 2), OUT_COL_W'(c - 1), OUT_ROW_W'(r),
                    1'b0, 1'b0};
        n++;
      end
      if (last_col) begin
        lft = (c == 0) ? 2 : 1;
        outs[n] = '{energy_at(top, 2, 2, lft, 2, 2), OUT_COL_W'(c), OUT_ROW_W'(r),
                    1'b0, 1'b1};
        n++;
      end
    end
    if (n > 0) outs[n - 1].last_in_run = 1'b1;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
    return n;
  endfunction

  // random pixel: flat gray, saturated channels or fully random
  function automatic pixel_t random_pixel();
    pixel_t           px;
    logic [PIX_W-1:0] base;
    case ($urandom_range(3))
      0: begin
        base = PIX_W'($urandom_range(255));
        px = '{red: base, green: base, blue: base};
      end
      1: begin
        px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: begin
        px = pixel_t'(24'($urandom));
      end
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  // one pixel transfer; valid is only lowered when a gap is taken
  task automatic send_pixel(input pixel_t px, input logic typed,
                            input logic [ENERGY_W-1:0] typed_energy);
    int          gap;
    int unsigned n;
    result_t     outs [4];
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= px;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    n = energy_for_pixel(px, outs);
    for (int k = 0; k < n; k++) begin
      if (typed) outs[k].energy = typed_energy;
      energies_due.push_back(outs[k]);
    end
  endtask

  // register write transfer, the predictor copy follows at the same edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) frame_w = value;
    else if (idx == REG_FRAME_HEIGHT) frame_h = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering pixels, wait for every owed energy, then let the last
  // pixel (which may release nothing) run to completion
  task automatic settle_idle();
    pix_valid <= 1'b0;
    while (energies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // compare one result transfer with the oldest owed energy
  task automatic check_energy(input result_t got);
    result_t want;
    if (energies_due.size() == 0) begin
      if (error_count < MAX_REPORTS)
        $display("unexpected result: energy %0d col %0d row %0d last %0b done %0b",
                 got.energy, got.out_col, got.out_row, got.last_in_run, got.frame_done);
      error_count++;
    end else begin
      want = energies_due.pop_front();
      if (got.energy !== want.energy || got.out_col !== want.out_col ||
          got.out_row !== want.out_row || got.last_in_run !== want.last_in_run ||
          got.frame_done !== want.frame_done) begin
        if (error_count < MAX_REPORTS)
          $display("mismatch: expected e=%0d c=%0d r=%0d l=%0b f=%0b,",
                   want.energy, want.out_col, want.out_row, want.last_in_run,
                   want.frame_done,
                   " got e=%0d c=%0d r=%0d l=%0b f=%0b",
                   got.energy, got.out_col, got.out_row, got.last_in_run, got.frame_done);
        error_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) check_energy(res);
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: reset, directed table, random frames
  // ---------------------------------------------------------------------------
  initial begin
    int          rand_sent;
    int          phase;
    int          prof;
    int          pick;
    int unsigned frame_px;
    int unsigned part;
    stim_row_t   row;

    pix_valid <= 1'b0;
    pix       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;

    // predictor reset
    frame_w = CFG_W'(WIDTH_RESET);
    frame_h = CFG_W'(HEIGHT_RESET);
    col_cnt = 0;
    row_cnt = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    error_count   = 0;
    stall_request = 0;

    // first profile: sender rarely idles, receiver often
    send_idle_pct = 8;
    recv_idle_pct = 54;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table; registers only change once the block has gone quiet
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        settle_idle();
        write_reg(row.idx, row.value);
      end else begin
        send_pixel(row.px, row.typed, row.energy);
      end
    end

    // random frames, small sizes; the idle profile moves on by thirds;
    // the last frame is cut where the item budget runs out
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      prof = rand_sent * 3 / RANDOM_ITEMS;
      send_idle_pct = (prof == 0) ? 8 : ((prof == 1) ? 54 : 0);
      recv_idle_pct = (prof == 0) ? 54 : ((prof == 1) ? 8 : 0);
      settle_idle();

      // new geometry, now and then only one register is rewritten
      pick = $urandom_range(2);
      if (pick != 1)
        write_reg(REG_FRAME_WIDTH, ($urandom_range(5) == 0) ? CFG_W'($urandom_range(9, 40))
                                                             : CFG_W'($urandom_range(0, 8)));
      if (pick != 2) write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 5)));
      frame_px = eff_size(frame_w, MAX_WIDTH) * eff_size(frame_h, MAX_HEIGHT);

      // long result hold-off while pixels keep coming, so the input stalls
      if (phase == 2) stall_request = STALL_CYCLES;

      if ($urandom_range(3) == 0 && frame_px > 1) begin
        // broken frame: pause mid-frame, resize, then run to the frame end
        part = $urandom_range(1, frame_px - 1);
        repeat (part) begin
          if (rand_sent < RANDOM_ITEMS) begin
            send_pixel(random_pixel(), 1'b0, '0);
            rand_sent++;
          end
        end
        settle_idle();
        // width never grows mid-frame, the line buffers past it hold nothing
        write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, eff_size(frame_w, MAX_WIDTH))));
        write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 6)));
        while ((col_cnt != 0 || row_cnt != 0) && rand_sent < RANDOM_ITEMS) begin
          send_pixel(random_pixel(), 1'b0, '0);
          rand_sent++;
        end
      end else begin
        // one or two whole frames
        repeat ($urandom_range(1, 2) * frame_px) begin
          if (rand_sent < RANDOM_ITEMS) begin
            send_pixel(random_pixel(), 1'b0, '0);
            rand_sent++;
          end
        end
      end
      phase++;
    end

    settle_idle();
    if (error_count == 0 && energies_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------------
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/rsem_pkg.sv
rtl/rsem_isqrt.sv
rtl/rgb_sobel_energy_map_top.sv
bench/testbench.sv
